### rtl/core/integer_to_text_formatter_top_defines.svh
// Assertion helpers for the integer formatter.
// Both macros sample on i_clk and are disabled while i_rst_n is low.
`ifndef INTEGER_TO_TEXT_FORMATTER_TOP_DEFINES_SVH
`define INTEGER_TO_TEXT_FORMATTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ITF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("integer formatter assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ITF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("integer formatter assertion failed");

`endif

### rtl/core/itf_pkg.sv
package itf_pkg;

    localparam int MAX_WIDTH_DEF = 64;
    localparam int MAX_PREC      = 60;
    localparam int VALUE_BITS    = 64;
    localparam int NUM_DIGITS    = 24;
    localparam int DEC_DIGITS    = 20;
    localparam int OCT_DIGITS    = 22;
    localparam int HEX_DIGITS    = 16;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LX    = 8'h78;

    typedef enum logic [1:0] {
        MODE_OCT  = 2'd0,
        MODE_DEC  = 2'd1,
        MODE_HEX  = 2'd2,
        MODE_NONE = 2'd3
    } t_mode;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic scan_step;
        logic prep;
        logic plan;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic conv_last;
        logic scan_hit;
        logic out_free;
        logic emit_last;
    } t_status;

endpackage

### rtl/core/itf_ctrl.sv
module itf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [1:0]        i_mode,
    input  itf_pkg::t_status  i_status,
    output itf_pkg::t_cmd     o_cmd,
    output logic              o_stall
);
    import itf_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_SCAN,
        S_PREP,
        S_PLAN,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    unique case (t_mode'(i_mode))
                        MODE_DEC:  n_state = S_CONV;
                        MODE_OCT:  n_state = S_SCAN;
                        MODE_HEX:  n_state = S_SCAN;
                        MODE_NONE: n_state = S_IDLE;
                    endcase
                end
            end
            S_CONV: begin
                o_cmd.conv_step = 1'b1;
                if (i_status.conv_last) n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_status.scan_hit) n_state = S_PREP;
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_PLAN;
            end
            S_PLAN: begin
                o_cmd.plan = 1'b1;
                n_state    = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
    end

    assign o_stall = r_busy;

endmodule

### rtl/core/itf_dp.sv
module itf_dp #(
    parameter int MAX_WIDTH = itf_pkg::MAX_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  itf_pkg::t_cmd     i_cmd,
    output itf_pkg::t_status  o_status,
    input  logic [63:0]       i_value,
    input  logic              i_is_signed,
    input  logic [1:0]        i_mode,
    input  logic              i_upper_case,
    input  logic              i_left_justify,
    input  logic              i_zero_pad,
    input  logic              i_plus_sign,
    input  logic              i_space_sign,
    input  logic              i_alternate_form,
    input  logic [6:0]        i_min_width,
    input  logic [5:0]        i_min_digits,
    input  logic              i_stall,
    output logic              o_valid,
    output logic [7:0]        o_ch,
    output logic              o_last
);
    import itf_pkg::*;

    localparam int         DIG_BITS = 4 * NUM_DIGITS;
    localparam logic [6:0] W_CAP    = 7'(MAX_WIDTH);

    // Octal and hex digits are plain bit slices; decimal starts from zero BCD.
    function automatic logic [DIG_BITS-1:0] slice_digits(input logic [63:0] mag,
                                                         input t_mode mode);
        logic [65:0]         ext;
        logic [DIG_BITS-1:0] d;
        int                  i;
        ext = {2'b00, mag};
        d   = '0;
        if (mode == MODE_OCT) begin
            for (i = 0; i < OCT_DIGITS; i++) d[4*i +: 4] = {1'b0, ext[3*i +: 3]};
        end else if (mode == MODE_HEX) begin
            for (i = 0; i < HEX_DIGITS; i++) d[4*i +: 4] = mag[4*i +: 4];
        end
        return d;
    endfunction

    // One double-dabble step: adjust each of the low 20 BCD digits, then shift a bit in.
    function automatic logic [DIG_BITS-1:0] dabble(input logic [DIG_BITS-1:0] d_in,
                                                   input logic bit_in);
        logic [DIG_BITS-1:0] d;
        logic [3:0]          nib;
        int                  i;
        d = d_in;
        for (i = 0; i < DEC_DIGITS; i++) begin
            nib = d[4*i +: 4];
            if (nib >= 4'd5) nib = nib + 4'd3;
            d[4*i +: 4] = nib;
        end
        return {d[DIG_BITS-2:0], bit_in};
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
        logic [7:0] c;
        if (nib < 4'd10) c = CH_ZERO + {4'b0000, nib};
        else if (upper)  c = CH_UA + {4'b0000, nib} - 8'd10;
        else             c = CH_LA + {4'b0000, nib} - 8'd10;
        return c;
    endfunction

    logic [63:0]         r_mag;
    logic [DIG_BITS-1:0] r_dig;
    logic [5:0]          r_bit;
    logic [4:0]          r_nd;
    logic [7:0]          r_sign_ch;
    logic                r_has_sign;
    logic [1:0]          r_pfx_len;
    logic [7:0]          r_x_ch;
    logic                r_upper;
    logic                r_left;
    logic                r_zpad;
    logic [6:0]          r_width;
    logic [5:0]          r_prec;
    logic [6:0]          r_content;
    logic [5:0]          r_zeros;
    logic [6:0]          r_b_lead;
    logic [6:0]          r_b_sign;
    logic [6:0]          r_b_pfx;
    logic [6:0]          r_b_zero;
    logic [6:0]          r_b_dig;
    logic [6:0]          r_total;
    logic [6:0]          r_k;
    logic                r_ovalid;
    logic [7:0]          r_och;
    logic                r_olast;

    t_mode       w_mode;
    logic        w_neg;
    logic [63:0] w_mag;
    logic [7:0]  w_sign_ch;
    logic        w_has_sign;
    logic [1:0]  w_pfx_len;
    logic [5:0]  w_nd6;
    logic [5:0]  w_prec_sat;
    logic [5:0]  w_prec_eff;
    logic [6:0]  w_wsat;
    logic [6:0]  w_pad;
    logic [6:0]  w_lead;
    logic [6:0]  w_b_sign;
    logic [6:0]  w_b_pfx;
    logic [6:0]  w_b_zero;
    logic [6:0]  w_b_dig;
    logic        w_in_dig;
    logic [7:0]  w_ch;
    logic        w_emit_last;

    // Item decode: sign, magnitude and prefix length.
    always_comb begin
        w_mode     = t_mode'(i_mode);
        w_neg      = i_is_signed & i_value[63];
        w_mag      = w_neg ? (64'd0 - i_value) : i_value;
        w_has_sign = w_neg | (i_is_signed & (i_plus_sign | i_space_sign));
        if (w_neg)            w_sign_ch = CH_MINUS;
        else if (i_plus_sign) w_sign_ch = CH_PLUS;
        else                  w_sign_ch = CH_SPACE;
        w_pfx_len = 2'd0;
        if (i_alternate_form) begin
            if (w_mode == MODE_HEX)      w_pfx_len = 2'd2;
            else if (w_mode == MODE_OCT) w_pfx_len = 2'd1;
        end
    end

    // Field layout.
    always_comb begin
        w_nd6      = {1'b0, r_nd};
        w_prec_sat = (r_prec > 6'(MAX_PREC)) ? 6'(MAX_PREC) : r_prec;
        w_prec_eff = (w_nd6 > w_prec_sat) ? w_nd6 : w_prec_sat;
        w_wsat     = (r_width > W_CAP) ? W_CAP : r_width;
        w_pad      = (w_wsat > r_content) ? (w_wsat - r_content) : 7'd0;
        w_lead     = (!r_zpad && !r_left) ? w_pad : 7'd0;
        w_b_sign   = w_lead + 7'(r_has_sign);
        w_b_pfx    = w_b_sign + 7'(r_pfx_len);
        w_b_zero   = w_b_pfx + (r_zpad ? w_pad : 7'd0) + {1'b0, r_zeros};
        w_b_dig    = w_b_zero + 7'(r_nd);
    end

    // Character at the current position of the run.
    always_comb begin
        w_in_dig = 1'b0;
        priority if (r_k < r_b_lead) begin
            w_ch = CH_SPACE;
        end else if (r_k < r_b_sign) begin
            w_ch = r_sign_ch;
        end else if (r_k < r_b_pfx) begin
            w_ch = (r_k == r_b_sign) ? CH_ZERO : r_x_ch;
        end else if (r_k < r_b_zero) begin
            w_ch = CH_ZERO;
        end else if (r_k < r_b_dig) begin
            w_ch     = digit_char(r_dig[DIG_BITS-1 -: 4], r_upper);
            w_in_dig = 1'b1;
        end else begin
            w_ch = CH_SPACE;
        end
        w_emit_last = ((r_k + 7'd1) == r_total);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag      <= w_mag;
            r_dig      <= slice_digits(w_mag, w_mode);
            r_bit      <= 6'(VALUE_BITS - 1);
            r_nd       <= 5'(NUM_DIGITS);
            r_sign_ch  <= w_sign_ch;
            r_has_sign <= w_has_sign;
            r_pfx_len  <= w_pfx_len;
            r_x_ch     <= i_upper_case ? CH_UX : CH_LX;
            r_upper    <= i_upper_case;
            r_left     <= i_left_justify;
            r_zpad     <= i_zero_pad & ~i_left_justify;
            r_width    <= i_min_width;
            r_prec     <= i_min_digits;
        end
        if (i_cmd.conv_step) begin
            r_dig <= dabble(r_dig, r_mag[63]);
            r_mag <= {r_mag[62:0], 1'b0};
            r_bit <= r_bit - 6'd1;
        end
        // Strip leading zero digits so the most significant one sits on top.
        if (i_cmd.scan_step && !o_status.scan_hit) begin
            r_dig <= {r_dig[DIG_BITS-5:0], 4'h0};
            r_nd  <= r_nd - 5'd1;
        end
        if (i_cmd.prep) begin
            r_content <= 7'(r_has_sign) + 7'(r_pfx_len) + {1'b0, w_prec_eff};
            r_zeros   <= w_prec_eff - w_nd6;
        end
        if (i_cmd.plan) begin
            r_b_lead <= w_lead;
            r_b_sign <= w_b_sign;
            r_b_pfx  <= w_b_pfx;
            r_b_zero <= w_b_zero;
            r_b_dig  <= w_b_dig;
            r_total  <= w_b_dig + (r_left ? w_pad : 7'd0);
            r_k      <= 7'd0;
        end
        if (i_cmd.emit) begin
            r_och   <= w_ch;
            r_olast <= w_emit_last;
            r_k     <= r_k + 7'd1;
            if (w_in_dig) r_dig <= {r_dig[DIG_BITS-5:0], 4'h0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    assign o_status.conv_last = (r_bit == 6'd0);
    assign o_status.scan_hit  = (r_dig[DIG_BITS-1 -: 4] != 4'h0) || (r_nd == 5'd1);
    assign o_status.out_free  = !r_ovalid || !i_stall;
    assign o_status.emit_last = w_emit_last;

    assign o_valid = r_ovalid;
    assign o_ch    = r_och;
    assign o_last  = r_olast;

endmodule

### rtl/core/integer_to_text_formatter_top.sv
// Integer to text formatter: takes one 64-bit value with radix, signedness, field width,
// precision and printf flags, and streams its text as ASCII characters, one item per
// character, with last set on the final one; radix code 3 produces no characters. An item
// is accepted only while o_stall is low, one at a time. A decimal item is accepted, then
// converted by a double-dabble BCD converter consuming one magnitude bit per cycle, then
// its leading zero digits are skipped, the field is laid out and its N characters (N at
// most 64 with the default MAX_WIDTH) leave one per cycle through the output register
// while that register is free; octal and hex slice digits directly and skip the
// conversion. The next item is taken as soon as the last character is in the
// output register, even while it still waits to be taken.
`include "integer_to_text_formatter_top_defines.svh"

module integer_to_text_formatter_top #(
    parameter int MAX_WIDTH = itf_pkg::MAX_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_value,
    input  logic        i_is_signed,
    input  logic [1:0]  i_mode,
    input  logic        i_upper_case,
    input  logic        i_left_justify,
    input  logic        i_zero_pad,
    input  logic        i_plus_sign,
    input  logic        i_space_sign,
    input  logic        i_alternate_form,
    input  logic [6:0]  i_min_width,
    input  logic [5:0]  i_min_digits,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_ch,
    output logic        o_last
);
    import itf_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    itf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_mode   (i_mode),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_stall  (o_stall)
    );

    itf_dp #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_value          (i_value),
        .i_is_signed      (i_is_signed),
        .i_mode           (i_mode),
        .i_upper_case     (i_upper_case),
        .i_left_justify   (i_left_justify),
        .i_zero_pad       (i_zero_pad),
        .i_plus_sign      (i_plus_sign),
        .i_space_sign     (i_space_sign),
        .i_alternate_form (i_alternate_form),
        .i_min_width      (i_min_width),
        .i_min_digits     (i_min_digits),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_ch             (o_ch),
        .o_last           (o_last)
    );

    // At most one datapath command is issued in any cycle.
    `ITF_ASSERT_IMP(a_one_cmd, 1'b1, $onehot0(w_cmd))
    // An item with a real radix keeps the block busy after it is taken.
    `ITF_ASSERT_NXT(a_accept_busy, i_valid && !o_stall && (i_mode != MODE_NONE), o_stall)
    // Sending the final character frees the input side in the next cycle.
    `ITF_ASSERT_NXT(a_last_frees, w_cmd.emit && w_status.emit_last, !o_stall)
    // A character is only loaded when the output register can take it.
    `ITF_ASSERT_IMP(a_emit_free, w_cmd.emit, !o_valid || !i_stall)

endmodule
